// ===== rtl/assert_macros.svh =====
// Assertion macros for the RefPack decompressor RTL.
// Uses the including module's clk and rst_n; define ASSERT_OFF to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/rplz_pkg.sv =====
// Shared constants for the RefPack decompressor: status codes, register indexes,
// command lengths, stop literal limit, header codes, skip lengths; no dependencies.
package rplz_pkg;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_BUSY         = 2'd1;
    localparam logic [1:0] STATUS_AFTER_FINISH = 2'd2;

    localparam logic REG_SLICE_START  = 1'b0;
    localparam logic REG_SLICE_LENGTH = 1'b1;

    localparam logic [2:0] CMD_LEN_1 = 3'd1;
    localparam logic [2:0] CMD_LEN_2 = 3'd2;
    localparam logic [2:0] CMD_LEN_3 = 3'd3;
    localparam logic [2:0] CMD_LEN_4 = 3'd4;

    localparam logic [7:0] STOP_LIT_MAX = 8'h70;

    localparam logic [1:0] HDR_SHORT      = 2'b00;
    localparam logic [1:0] HDR_SHORT_WIDE = 2'b01;
    localparam logic [1:0] HDR_LONG       = 2'b10;
    localparam logic [1:0] HDR_LONG_WIDE  = 2'b11;

    localparam logic [3:0] HDR_LEFT_SHORT      = 4'd4;
    localparam logic [3:0] HDR_LEFT_SHORT_WIDE = 4'd7;
    localparam logic [3:0] HDR_LEFT_LONG       = 4'd5;
    localparam logic [3:0] HDR_LEFT_LONG_WIDE  = 4'd9;

endpackage

// ===== rtl/refpack_lz_decompressor.sv =====
// RefPack LZ decompressor top level: header skip, command decode, window copy.
// Depends on rplz_pkg and assert_macros.svh.
// An accepted item passes through the s1 registers and then the result registers;
// one item per cycle while in_stall is low. The window memory has one read and one write
// port and a registered read; a write issued at the same edge is forwarded to that read.
// Reset clears all control state; the window memory is undefined until written.
`include "assert_macros.svh"
module refpack_lz_decompressor
    import rplz_pkg::*;
#(
    parameter int WINDOW_DEPTH = 131072
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  in_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        out_valid,
    output logic [7:0]  out_byte,
    output logic        out_last,
    output logic        copy_pending,
    output logic        finished,
    output logic [1:0]  status
);

    localparam int AW = $clog2(WINDOW_DEPTH);

    logic [7:0] win_mem [WINDOW_DEPTH];
    logic [7:0] mem_rdata_reg;

    logic [31:0] slice_start_reg;
    logic [31:0] slice_length_reg;

    logic          hdr_seen_reg, hdr_seen_next;
    logic [3:0]    hdr_left_reg, hdr_left_next;
    logic [23:0]   cmd_reg, cmd_next;
    logic [1:0]    idx_reg, idx_next;
    logic [6:0]    lit_reg, lit_next;
    logic [10:0]   copy_reg, copy_next;
    logic [AW-1:0] src_reg, src_next;
    logic [31:0]   pos_reg, pos_next;
    logic          done_reg, done_next;
    logic          stop_reg, stop_next;

    logic          s1_valid_reg;
    logic          s1_out_valid_reg;
    logic          s1_last_reg;
    logic          s1_cp_reg;
    logic          s1_fin_reg;
    logic [1:0]    s1_status_reg;
    logic          s1_wr_reg;
    logic [AW-1:0] s1_waddr_reg;
    logic          s1_from_mem_reg;
    logic [7:0]    s1_byte_reg;
    logic          s1_fwd_reg;
    logic [7:0]    s1_fwd_data_reg;
    logic [7:0]    s1_byte_cur;

    logic       res_valid_reg;
    logic       res_out_valid_reg;
    logic [7:0] res_byte_reg;
    logic       res_last_reg;
    logic       res_cp_reg;
    logic       res_fin_reg;
    logic [1:0] res_status_reg;

    logic out_free, s1_move, accept, rd_en, mem_we, cfg_we;
    logic s_emit, s_from_mem;
    logic [7:0] s_byte;
    logic [1:0] s_status;
    logic [32:0] slice_end;
    logic in_slice, slice_last;

    logic [7:0]  b0, b1, b2, b3;
    logic [2:0]  cmd_len;
    logic        cmd_done;
    logic [6:0]  dec_lit;
    logic [7:0]  dec_lit1;
    logic [10:0] dec_cp;
    logic [17:0] dec_dist;
    logic        dec_stop;
    logic [AW:0] dec_src_sum;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_SLICE_LENGTH) ? slice_length_reg : slice_start_reg;

    assign out_free = !res_valid_reg || !result_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;
    assign mem_we   = s1_move && s1_wr_reg;

    assign s1_byte_cur = !s1_from_mem_reg ? s1_byte_reg :
                         (s1_fwd_reg ? s1_fwd_data_reg : mem_rdata_reg);

    assign slice_end  = {1'b0, slice_start_reg} + {1'b0, slice_length_reg};
    assign in_slice   = (pos_reg >= slice_start_reg) && ({1'b0, pos_reg} < slice_end);
    assign slice_last = in_slice && (({1'b0, pos_reg} + 33'd1) == slice_end);

    always_comb
    begin
        b0 = (idx_reg == 2'd0) ? in_byte : cmd_reg[7:0];
        b1 = (idx_reg == 2'd1) ? in_byte : cmd_reg[15:8];
        b2 = (idx_reg == 2'd2) ? in_byte : cmd_reg[23:16];
        b3 = in_byte;
        if (!b0[7])
            cmd_len = CMD_LEN_2;
        else if (!b0[6])
            cmd_len = CMD_LEN_3;
        else if (!b0[5])
            cmd_len = CMD_LEN_4;
        else
            cmd_len = CMD_LEN_1;
        cmd_done = ({1'b0, idx_reg} + 3'd1) >= cmd_len;
        dec_lit1 = {1'b0, b0[4:0], 2'b00} + 8'd4;
        dec_stop = 1'b0;
        case (cmd_len)
            CMD_LEN_2:
            begin
                dec_lit  = {5'd0, b0[1:0]};
                dec_cp   = {8'd0, b0[4:2]} + 11'd3;
                dec_dist = {8'd0, b0[6:5], b1} + 18'd1;
            end
            CMD_LEN_3:
            begin
                dec_lit  = {5'd0, b1[7:6]};
                dec_cp   = {5'd0, b0[5:0]} + 11'd4;
                dec_dist = {4'd0, b1[5:0], b2} + 18'd1;
            end
            CMD_LEN_4:
            begin
                dec_lit  = {5'd0, b0[1:0]};
                dec_cp   = {1'b0, b0[3:2], b3} + 11'd5;
                dec_dist = {1'b0, b0[4], b1, b2} + 18'd1;
            end
            default:
            begin
                dec_cp   = 11'd0;
                dec_dist = 18'd1;
                if (dec_lit1 > STOP_LIT_MAX)
                begin
                    dec_lit  = {5'd0, b0[1:0]};
                    dec_stop = 1'b1;
                end
                else
                begin
                    dec_lit = dec_lit1[6:0];
                end
            end
        endcase
        dec_src_sum = {1'b0, pos_reg[AW-1:0]} + (AW+1)'(dec_lit) - (AW+1)'(dec_dist);
    end

    always_comb
    begin
        hdr_seen_next = hdr_seen_reg;
        hdr_left_next = hdr_left_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        lit_next      = lit_reg;
        copy_next     = copy_reg;
        src_next      = src_reg;
        pos_next      = pos_reg;
        done_next     = done_reg;
        stop_next     = stop_reg;
        rd_en         = 1'b0;
        s_emit        = 1'b0;
        s_from_mem    = 1'b0;
        s_byte        = 8'd0;
        s_status      = STATUS_OK;
        if (accept)
        begin
            if (done_reg)
            begin
                s_status = STATUS_AFTER_FINISH;
            end
            else if (req_type)
            begin
                if (lit_reg == 7'd0 && copy_reg != 11'd0)
                begin
                    rd_en      = 1'b1;
                    src_next   = src_reg + AW'(1);
                    copy_next  = copy_reg - 11'd1;
                    s_emit     = 1'b1;
                    s_from_mem = 1'b1;
                end
            end
            else if (lit_reg == 7'd0 && copy_reg != 11'd0)
            begin
                s_status = STATUS_BUSY;
            end
            else if (!hdr_seen_reg)
            begin
                hdr_seen_next = 1'b1;
                case ({in_byte[7], in_byte[0]})
                    HDR_SHORT:      hdr_left_next = HDR_LEFT_SHORT;
                    HDR_SHORT_WIDE: hdr_left_next = HDR_LEFT_SHORT_WIDE;
                    HDR_LONG:       hdr_left_next = HDR_LEFT_LONG;
                    HDR_LONG_WIDE:  hdr_left_next = HDR_LEFT_LONG_WIDE;
                    default:        hdr_left_next = HDR_LEFT_SHORT;
                endcase
            end
            else if (hdr_left_reg != 4'd0)
            begin
                hdr_left_next = hdr_left_reg - 4'd1;
            end
            else if (lit_reg != 7'd0)
            begin
                lit_next = lit_reg - 7'd1;
                s_emit   = 1'b1;
                s_byte   = in_byte;
                if (lit_reg == 7'd1 && stop_reg)
                    done_next = 1'b1;
            end
            else
            begin
                case (idx_reg)
                    2'd0:    cmd_next[7:0]   = in_byte;
                    2'd1:    cmd_next[15:8]  = in_byte;
                    2'd2:    cmd_next[23:16] = in_byte;
                    default: cmd_next        = cmd_reg;
                endcase
                idx_next = idx_reg + 2'd1;
                if (cmd_done)
                begin
                    idx_next  = 2'd0;
                    lit_next  = dec_lit;
                    copy_next = dec_cp;
                    src_next  = dec_src_sum[AW-1:0];
                    if (dec_stop)
                    begin
                        stop_next = 1'b1;
                        if (dec_lit == 7'd0)
                            done_next = 1'b1;
                    end
                end
            end
            if (s_emit)
            begin
                pos_next = pos_reg + 32'd1;
                if (slice_last)
                    done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_start_reg  <= 32'd0;
            slice_length_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_SLICE_LENGTH)
                slice_length_reg <= pwdata;
            else
                slice_start_reg <= pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_seen_reg <= 1'b0;
            hdr_left_reg <= 4'd0;
            cmd_reg      <= 24'd0;
            idx_reg      <= 2'd0;
            lit_reg      <= 7'd0;
            copy_reg     <= 11'd0;
            src_reg      <= '0;
            pos_reg      <= 32'd0;
            done_reg     <= 1'b0;
            stop_reg     <= 1'b0;
        end
        else
        begin
            hdr_seen_reg <= hdr_seen_next;
            hdr_left_reg <= hdr_left_next;
            cmd_reg      <= cmd_next;
            idx_reg      <= idx_next;
            lit_reg      <= lit_next;
            copy_reg     <= copy_next;
            src_reg      <= src_next;
            pos_reg      <= pos_next;
            done_reg     <= done_next;
            stop_reg     <= stop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            win_mem[s1_waddr_reg] <= s1_byte_cur;
        if (rd_en)
            mem_rdata_reg <= win_mem[src_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_out_valid_reg <= s_emit && in_slice;
            s1_last_reg      <= s_emit && slice_last;
            s1_cp_reg        <= !done_next && lit_next == 7'd0 && copy_next != 11'd0;
            s1_fin_reg       <= done_next;
            s1_status_reg    <= s_status;
            s1_wr_reg        <= s_emit;
            s1_waddr_reg     <= pos_reg[AW-1:0];
            s1_from_mem_reg  <= s_from_mem;
            s1_byte_reg      <= s_byte;
            s1_fwd_reg       <= rd_en && mem_we && (s1_waddr_reg == src_reg);
            s1_fwd_data_reg  <= s1_byte_cur;
        end
        else if (s1_valid_reg && !s1_move)
        begin
            // hold the fetched byte while the result side stalls
            s1_byte_reg     <= s1_byte_cur;
            s1_from_mem_reg <= 1'b0;
            s1_fwd_reg      <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (s1_move)
            res_valid_reg <= 1'b1;
        else if (!result_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_out_valid_reg <= s1_out_valid_reg;
            res_byte_reg      <= s1_byte_cur;
            res_last_reg      <= s1_last_reg;
            res_cp_reg        <= s1_cp_reg;
            res_fin_reg       <= s1_fin_reg;
            res_status_reg    <= s1_status_reg;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_valid    = res_out_valid_reg;
    assign out_byte     = res_byte_reg;
    assign out_last     = res_last_reg;
    assign copy_pending = res_cp_reg;
    assign finished     = res_fin_reg;
    assign status       = res_status_reg;

    `ASSERT_CLK(a_no_write_after_done, (accept && done_reg) |=> !s1_wr_reg, "write after finish")
    `ASSERT_CLK(a_pos_tracks_write, accept |=> (s1_wr_reg == (pos_reg != $past(pos_reg))),
                "position and window write disagree")
    `ASSERT_CLK(a_fwd_only_on_fetch, (s1_valid_reg && s1_fwd_reg) |-> s1_from_mem_reg,
                "forward without window fetch")
    `ASSERT_CLK(a_done_sticky, done_reg |=> done_reg, "finish flag cleared")

endmodule

// ===== sim/rplz_checker.sv =====
`timescale 1ns / 100ps
// Checker for refpack_lz_decompressor: watches the APB, item and result channels,
// predicts every result from its own decoder copy and compares. Depends on rplz_pkg.
module rplz_checker
    import rplz_pkg::*;
#(
    parameter int WINDOW_DEPTH = 131072
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  in_byte,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic        out_valid,
    input  logic [7:0]  out_byte,
    input  logic        out_last,
    input  logic        copy_pending,
    input  logic        finished,
    input  logic [1:0]  status,
    output int          fail_count,
    output int          open_count
);

    localparam int WIN_BITS = $clog2(WINDOW_DEPTH);

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       out_last;
        logic       copy_pending;
        logic       finished;
        logic [1:0] status;
    } lz_result_t;

    logic [7:0]          window_mem [WINDOW_DEPTH];
    logic [31:0]         slice_start;
    logic [31:0]         slice_len;
    logic [3:0]          hdr_left;
    logic                hdr_seen;
    logic [31:0]         cmd_bytes;
    logic [2:0]          cmd_idx;
    logic [6:0]          lit_left;
    logic [10:0]         copy_left;
    logic [WIN_BITS-1:0] copy_src;
    logic [31:0]         pos;
    logic                done;
    logic                stop_pending;
    lz_result_t          predicted_out [$];
    int                  bad_count;

    function automatic void put_byte(input logic [7:0] v, inout lz_result_t r);
        logic [32:0] stop_at;
        stop_at = {1'b0, slice_start} + {1'b0, slice_len};
        r.out_valid = (pos >= slice_start) && ({1'b0, pos} < stop_at);
        r.out_byte = v;
        r.out_last = r.out_valid && ({1'b0, pos} + 33'd1 == stop_at);
        window_mem[pos[WIN_BITS-1:0]] = v;
        pos = pos + 32'd1;
        if (r.out_last)
            done = 1'b1;
    endfunction

    function automatic lz_result_t decompress_step(input logic req, input logic [7:0] b);
        lz_result_t  r;
        logic [2:0]  clen;
        logic [7:0]  b0, b1, b2, b3, lit8;
        logic [10:0] cp;
        logic [17:0] distance;
        logic [31:0] src;
        r = '0;
        r.status = STATUS_OK;
        if (done)
            r.status = STATUS_AFTER_FINISH;
        else if (req)
        begin
            if (lit_left == 0 && copy_left != 0)
            begin
                b0 = window_mem[copy_src];
                copy_src = copy_src + 1'b1;
                copy_left = copy_left - 11'd1;
                put_byte(b0, r);
            end
        end
        else if (lit_left == 0 && copy_left != 0)
            r.status = STATUS_BUSY;
        else if (!hdr_seen)
        begin
            hdr_seen = 1'b1;
            case ({b[7], b[0]})
                HDR_SHORT:      hdr_left = HDR_LEFT_SHORT;
                HDR_SHORT_WIDE: hdr_left = HDR_LEFT_SHORT_WIDE;
                HDR_LONG:       hdr_left = HDR_LEFT_LONG;
                default:        hdr_left = HDR_LEFT_LONG_WIDE;
            endcase
        end
        else if (hdr_left != 0)
            hdr_left = hdr_left - 4'd1;
        else if (lit_left != 0)
        begin
            lit_left = lit_left - 7'd1;
            put_byte(b, r);
            if (lit_left == 0 && stop_pending)
                done = 1'b1;
        end
        else
        begin
            cmd_bytes[8*cmd_idx +: 8] = b;
            cmd_idx = cmd_idx + 3'd1;
            if (!cmd_bytes[7])
                clen = CMD_LEN_2;
            else if (!cmd_bytes[6])
                clen = CMD_LEN_3;
            else if (!cmd_bytes[5])
                clen = CMD_LEN_4;
            else
                clen = CMD_LEN_1;
            if (cmd_idx >= clen)
            begin
                b0 = cmd_bytes[7:0];
                b1 = cmd_bytes[15:8];
                b2 = cmd_bytes[23:16];
                b3 = cmd_bytes[31:24];
                case (clen)
                    CMD_LEN_2:
                    begin
                        lit8 = 8'(b0[1:0]);
                        cp = 11'(b0[4:2]) + 11'd3;
                        distance = 18'({b0[6:5], b1}) + 18'd1;
                    end
                    CMD_LEN_3:
                    begin
                        lit8 = 8'(b1[7:6]);
                        cp = 11'(b0[5:0]) + 11'd4;
                        distance = 18'({b1[5:0], b2}) + 18'd1;
                    end
                    CMD_LEN_4:
                    begin
                        lit8 = 8'(b0[1:0]);
                        cp = 11'({b0[3:2], b3}) + 11'd5;
                        distance = 18'({b0[4], b1, b2}) + 18'd1;
                    end
                    default:
                    begin
                        lit8 = 8'({b0[4:0], 2'b00}) + 8'd4;
                        if (lit8 > STOP_LIT_MAX)
                        begin
                            lit8 = 8'(b0[1:0]);
                            stop_pending = 1'b1;
                        end
                        cp = '0;
                        distance = 18'd1;
                    end
                endcase
                lit_left = lit8[6:0];
                copy_left = cp;
                src = 32'(pos[WIN_BITS-1:0]) + 32'(lit8) + 32'(WINDOW_DEPTH) - 32'(distance);
                copy_src = src[WIN_BITS-1:0];
                if (stop_pending && lit8 == 0)
                    done = 1'b1;
                cmd_idx = '0;
                cmd_bytes = '0;
            end
        end
        r.copy_pending = !done && lit_left == 0 && copy_left != 0;
        r.finished = done;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lz_result_t want, got;
        if (!rst_n)
        begin
            slice_start = '0;
            slice_len = 32'd1;
            hdr_left = '0;
            hdr_seen = 1'b0;
            cmd_bytes = '0;
            cmd_idx = '0;
            lit_left = '0;
            copy_left = '0;
            copy_src = '0;
            pos = '0;
            done = 1'b0;
            stop_pending = 1'b0;
            predicted_out.delete();
            bad_count = 0;
            fail_count <= 0;
            open_count <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_SLICE_START, 2'b00})
                    slice_start = pwdata;
                else if (paddr == {REG_SLICE_LENGTH, 2'b00})
                    slice_len = pwdata;
            end
            if (result_valid && !result_stall)
            begin
                if (predicted_out.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("result with no item outstanding at %0t: byte=%02h st=%0d",
                                 $time, out_byte, status);
                end
                else
                begin
                    want = predicted_out.pop_front();
                    got = {out_valid, out_byte, out_last, copy_pending, finished, status};
                    if (got !== want)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                        begin
                            $display("mismatch %0t: want v=%0b b=%02h l=%0b p=%0b f=%0b s=%0d",
                                     $time, want.out_valid, want.out_byte, want.out_last,
                                     want.copy_pending, want.finished, want.status);
                            $display("    got v=%0b b=%02h l=%0b p=%0b f=%0b s=%0d",
                                     got.out_valid, got.out_byte, got.out_last,
                                     got.copy_pending, got.finished, got.status);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                predicted_out.push_back(decompress_step(req_type, in_byte));
            fail_count <= bad_count;
            open_count <= predicted_out.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for refpack_lz_decompressor: clock, reset, APB slice setup, compressed
// stream stimulus with random idling, watchdog, verdict. Uses rplz_pkg, rplz_checker, the DUT.
module tb
    import rplz_pkg::*;
();

    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 250;
    localparam int PHASES      = 7;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  in_byte;
    logic        result_valid;
    logic        result_stall;
    logic        out_valid;
    logic [7:0]  out_byte;
    logic        out_last;
    logic        copy_pending;
    logic        finished;
    logic [1:0]  status;
    int          fail_count;
    int          open_count;

    bit quiet;
    int items_sent;
    int out_count;

    refpack_lz_decompressor u_top (.*);

    rplz_checker u_checker (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic send_item(input logic req, input logic [7:0] b);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        in_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_slice(input logic [31:0] first, input logic [31:0] count);
        write_reg({REG_SLICE_START, 2'b00}, first);
        write_reg({REG_SLICE_LENGTH, 2'b00}, count);
    endtask

    // hold the sender until every result is back, then let the pipeline settle
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (open_count != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic send_command();
        int pick, lit, cp, distance, reach, k, nb;
        logic [16:0] d;
        logic [7:0] cb [4];
        if ($urandom_range(0, 19) == 0)
            quiet = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 9) == 0)
            send_item(1'b1, 8'($urandom));
        pick = $urandom_range(0, 99);
        lit = $urandom_range(0, 3);
        reach = out_count + lit;
        cp = 0;
        nb = 1;
        if (pick < 15 || reach == 0)
        begin
            k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 27) : $urandom_range(0, 3);
            lit = 4 * k + 4;
            cb[0] = 8'hE0 | 8'(k);
        end
        else if (pick < 60)
        begin
            cp = $urandom_range(3, 10);
            distance = $urandom_range(1, (reach < 1024) ? reach : 1024);
            d = 17'(distance - 1);
            cb[0] = {1'b0, d[9:8], 3'(cp - 3), 2'(lit)};
            cb[1] = d[7:0];
            nb = 2;
        end
        else if (pick < 88)
        begin
            cp = $urandom_range(4, 67);
            distance = $urandom_range(1, (reach < 16384) ? reach : 16384);
            d = 17'(distance - 1);
            cb[0] = {2'b10, 6'(cp - 4)};
            cb[1] = {2'(lit), d[13:8]};
            cb[2] = d[7:0];
            nb = 3;
        end
        else
        begin
            cp = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 1028) : $urandom_range(5, 40);
            distance = $urandom_range(1, (reach < 131072) ? reach : 131072);
            d = 17'(distance - 1);
            k = cp - 5;
            cb[0] = {3'b110, d[16], 2'(k >> 8), 2'(lit)};
            cb[1] = d[15:8];
            cb[2] = d[7:0];
            cb[3] = 8'(k);
            nb = 4;
        end
        for (int i = 0; i < nb; i++)
        begin
            if (i > 0 && $urandom_range(0, 15) == 0)
                send_item(1'b1, 8'($urandom));
            send_item(1'b0, cb[i]);
        end
        for (int i = 0; i < lit; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(1'b1, 8'($urandom));
            send_item(1'b0, 8'($urandom));
        end
        out_count += lit;
        for (int i = 0; i < cp; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(1'b0, 8'($urandom));
            send_item(1'b1, 8'($urandom));
        end
        out_count += cp;
    endtask

    initial
    begin : receiver
        int wait_cycles;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            wait_cycles = quiet ? 0 : $urandom_range(0, 10);
            if (wait_cycles > 0)
            begin
                result_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (!result_valid) @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (result_valid && !result_stall) ||
                (psel && penable && pready))
                idle = 0;
            else
                idle++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        logic [7:0]  head;
        logic [31:0] first;
        logic [3:0]  skip;
        int          k;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        req_type = 1'b0;
        in_byte = '0;
        quiet = 1'b0;
        items_sent = 0;
        out_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < PHASES; p++)
        begin
            drain(4);
            case (p)
                0: set_slice(32'd0, 32'hFFFF_FFFF);
                1: set_slice(32'hFFFF_FFFF, 32'hFFFF_FFFF);
                2: set_slice($urandom, 32'd0);
                3: set_slice(32'(out_count + $urandom_range(0, 300)),
                             $urandom_range(32'h0010_0000, 32'hFFFF_FFFF));
                4: set_slice(32'hFFFF_FFFF, 32'd1);
                5: set_slice(32'($urandom_range(0, out_count)),
                             $urandom_range(32'h0010_0000, 32'hFFFF_FFFF));
                default: set_slice(32'($urandom_range(0, out_count)), 32'hFFFF_FFFF);
            endcase
            if (p == 0)
            begin
                send_item(1'b1, 8'h00);
                head = 8'($urandom);
                case ({head[7], head[0]})
                    HDR_SHORT:      skip = HDR_LEFT_SHORT;
                    HDR_SHORT_WIDE: skip = HDR_LEFT_SHORT_WIDE;
                    HDR_LONG:       skip = HDR_LEFT_LONG;
                    default:        skip = HDR_LEFT_LONG_WIDE;
                endcase
                send_item(1'b0, head);
                repeat (skip) send_item(1'b0, 8'($urandom));
                send_item(1'b0, 8'hE0);
                send_item(1'b0, 8'h00);
                send_item(1'b0, 8'hFF);
                send_item(1'b1, 8'hFF);
                send_item(1'b0, 8'h5A);
                send_item(1'b0, 8'hA5);
                send_item(1'b0, 8'h04);
                send_item(1'b0, 8'h03);
                // drop: arrives while the copy is pending
                send_item(1'b0, 8'hFF);
                repeat (4) send_item(1'b1, 8'h00);
                send_item(1'b1, 8'hFF);
                out_count = 8;
            end
            while (items_sent < (p + 1) * PHASE_ITEMS)
                send_command();
        end

        // close the slice on the last literal of a stop code
        drain(4);
        k = $urandom_range(1, 3);
        first = 32'(out_count - $urandom_range(0, (out_count < 40) ? out_count : 40));
        set_slice(first, 32'(out_count + k) - first);
        send_item(1'b0, 8'hFC | 8'(k));
        repeat (k) send_item(1'b0, 8'($urandom));
        repeat (12) send_item(1'($urandom_range(0, 1)), 8'($urandom));
        drain(8);

        if (fail_count == 0 && open_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
